>>> rtl/tfst_pkg.sv
// shared types, codes and constants of the tcp flow sequence tracker
package tfst_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic OP_OPEN    = 1'b0;
	localparam logic OP_SEGMENT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_CLOSED  = 3'd1,
		ST_GAP     = 3'd2,
		ST_OOO     = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_NOPRIOR = 3'd5
	} status_t;

	// one decoded packet header as it travels from front to back
	typedef struct packed {
		logic        operation;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [15:0] payload_len;
		logic        syn_flag;
		logic        fin_flag;
		logic        rst_flag;
		logic        syn_or_fin;
		logic        has_payload;
	} item_t;

endpackage

>>> rtl/tfst_if.sv
// handshake channels for packet headers and tracker results
interface tfst_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] src_addr;
	logic [15:0] src_port;
	logic [31:0] dst_addr;
	logic [15:0] dst_port;
	logic [31:0] seq_num;
	logic [31:0] ack_num;
	logic [15:0] payload_len;
	logic        syn_flag;
	logic        fin_flag;
	logic        rst_flag;

	modport source (
		output valid, operation, src_addr, src_port, dst_addr, dst_port,
			seq_num, ack_num, payload_len, syn_flag, fin_flag, rst_flag,
		input ready
	);
	modport sink (
		input valid, operation, src_addr, src_port, dst_addr, dst_port,
			seq_num, ack_num, payload_len, syn_flag, fin_flag, rst_flag,
		output ready
	);
endinterface

interface tfst_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        deliver_payload;
	logic [31:0] packet_count;
	logic        flow_closed;

	modport source (
		output valid, status, deliver_payload, packet_count, flow_closed,
		input ready
	);
	modport sink (
		input valid, status, deliver_payload, packet_count, flow_closed,
		output ready
	);
endinterface

>>> rtl/tcp_flow_sequence_tracker_top.sv
// top level: input stage, header queue and flow state engine of the tcp flow tracker
// path: a header beat is registered in the input stage, then written into the queue, then its
// result is registered by the flow state engine and held until the result side takes it
// throughput: one header per cycle unless a side stalls; the engine settles one item per cycle
// and the four-entry queue lets input and result sides stall independently
// reset: arst_n clears all control state at once; no session is open afterward
module tcp_flow_sequence_tracker_top (
	input  logic      clk,
	input  logic      arst_n,
	tfst_in_if.sink   pkt,
	tfst_out_if.source res
);
	import tfst_pkg::*;

	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	item_t head;

	tfst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	tfst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	tfst_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.h       (head),
		.pop     (pop),
		.res     (res)
	);

endmodule

>>> rtl/tfst_front.sv
// input stage: registers each header beat and precomputes its flags
module tfst_front (
	input  logic            clk,
	input  logic            arst_n,
	tfst_in_if.sink         pkt,
	input  logic            q_full,
	output logic            push,
	output tfst_pkg::item_t push_item
);
	import tfst_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign pkt.ready = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			item_s1.operation   <= pkt.operation;
			item_s1.src_addr    <= pkt.src_addr;
			item_s1.src_port    <= pkt.src_port;
			item_s1.dst_addr    <= pkt.dst_addr;
			item_s1.dst_port    <= pkt.dst_port;
			item_s1.seq_num     <= pkt.seq_num;
			item_s1.ack_num     <= pkt.ack_num;
			item_s1.payload_len <= pkt.payload_len;
			item_s1.syn_flag    <= pkt.syn_flag;
			item_s1.fin_flag    <= pkt.fin_flag;
			item_s1.rst_flag    <= pkt.rst_flag;
			item_s1.syn_or_fin  <= pkt.syn_flag | pkt.fin_flag;
			item_s1.has_payload <= |pkt.payload_len;
		end
	end

endmodule

>>> rtl/tfst_queue.sv
// short fifo between the input stage and the flow state engine
module tfst_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tfst_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output tfst_pkg::item_t head
);
	import tfst_pkg::*;

	item_t           mem [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign full  = (count_q == (QPtrW+1)'(QDepth));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPtrW+1)'(QDepth)) else $error("queue count out of range");

endmodule

>>> rtl/tfst_back.sv
// flow state engine: opens a flow or checks each segment against it, and registers the result
module tfst_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  tfst_pkg::item_t h,
	output logic            pop,
	tfst_out_if.source      res
);
	import tfst_pkg::*;

	// flow state
	logic        session_open_q;
	logic [31:0] ep_src_addr_q;
	logic [15:0] ep_src_port_q;
	logic [31:0] ep_dst_addr_q;
	logic [15:0] ep_dst_port_q;
	logic [1:0]  have_last_q;
	logic [31:0] last_seq_q [2];
	logic [15:0] last_len_q [2];
	logic [1:0]  last_sf_q;
	logic [1:0]  fin_seen_q;
	logic [31:0] fin_ack_q [2];
	logic [1:0]  side_closed_q;
	logic [31:0] count_reg_q;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic        deliver_q;
	logic [31:0] count_out_q;
	logic        closed_q;

	// next-state decisions
	logic        dir_src;
	logic        dir_dst;
	logic        d;
	logic        o;
	logic [31:0] next_seq;
	status_t     st;
	logic        deliver;
	logic        do_open;
	logic        do_keep;
	logic        do_bump;
	logic        do_rst;
	logic        set_fin;
	logic        close_o;
	logic [31:0] count_bumped;
	logic [31:0] count_nxt;
	logic [1:0]  closed_nxt;

	assign pop = !q_empty && (!out_valid_q || res.ready);

	assign dir_src  = (h.src_addr == ep_src_addr_q) && (h.src_port == ep_src_port_q);
	assign dir_dst  = (h.src_addr == ep_dst_addr_q) && (h.src_port == ep_dst_port_q);
	assign d        = !dir_src;
	assign o        = ~d;
	assign next_seq = last_seq_q[d] + (last_sf_q[d] ? 32'd1 : {16'd0, last_len_q[d]});
	assign count_bumped = (count_reg_q == '1) ? count_reg_q : count_reg_q + 32'd1;

	always_comb begin
		st      = ST_OK;
		deliver = 1'b0;
		do_open = 1'b0;
		do_keep = 1'b0;
		do_bump = 1'b0;
		do_rst  = 1'b0;
		set_fin = 1'b0;
		close_o = 1'b0;
		if (h.operation == OP_OPEN) begin
			do_open = 1'b1;
		end else if (!session_open_q) begin
			st = ST_NOPRIOR;
		end else if (&side_closed_q) begin
			st = ST_CLOSED;
		end else if (h.rst_flag) begin
			do_rst  = 1'b1;
			do_bump = 1'b1;
		end else if (!dir_src && !dir_dst) begin
			st = ST_UNKNOWN;
		end else if (!have_last_q[d] && h.syn_flag) begin
			// first syn of a direction is recorded but not counted
			do_keep = 1'b1;
		end else if (!have_last_q[d]) begin
			st = ST_NOPRIOR;
		end else if (next_seq == h.seq_num) begin
			do_keep = 1'b1;
			do_bump = 1'b1;
			if (h.has_payload) begin
				deliver = 1'b1;
			end else begin
				set_fin = !fin_seen_q[d] && h.fin_flag;
				close_o = fin_seen_q[o] && (h.seq_num == fin_ack_q[o]);
			end
		end else if (next_seq > h.seq_num) begin
			st = ST_OOO;
		end else begin
			st = ST_GAP;
		end
	end

	always_comb begin
		count_nxt = count_reg_q;
		if (do_open) begin
			count_nxt = 32'd1;
		end else if (do_bump) begin
			count_nxt = count_bumped;
		end
		closed_nxt = side_closed_q;
		if (do_open) begin
			closed_nxt = 2'b00;
		end else if (do_rst) begin
			closed_nxt = 2'b11;
		end else if (close_o) begin
			closed_nxt[o] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_open_q <= 1'b0;
			ep_src_addr_q  <= '0;
			ep_src_port_q  <= '0;
			ep_dst_addr_q  <= '0;
			ep_dst_port_q  <= '0;
			have_last_q    <= '0;
			fin_seen_q     <= '0;
			side_closed_q  <= '0;
			count_reg_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q   <= 1'b1;
				count_reg_q   <= count_nxt;
				side_closed_q <= closed_nxt;
				if (do_open) begin
					session_open_q <= 1'b1;
					ep_src_addr_q  <= h.src_addr;
					ep_src_port_q  <= h.src_port;
					ep_dst_addr_q  <= h.dst_addr;
					ep_dst_port_q  <= h.dst_port;
					have_last_q    <= 2'b01;
					fin_seen_q     <= 2'b00;
				end else begin
					if (do_keep) begin
						have_last_q[d] <= 1'b1;
					end
					if (set_fin) begin
						fin_seen_q[d] <= 1'b1;
					end
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (do_open) begin
				last_seq_q[0] <= h.seq_num;
				last_len_q[0] <= h.payload_len;
				last_sf_q[0]  <= h.syn_or_fin;
			end else if (do_keep) begin
				last_seq_q[d] <= h.seq_num;
				last_len_q[d] <= h.payload_len;
				last_sf_q[d]  <= h.syn_or_fin;
			end
			if (set_fin) begin
				fin_ack_q[d] <= h.ack_num;
			end
			status_q    <= st;
			deliver_q   <= deliver;
			count_out_q <= count_nxt;
			closed_q    <= &closed_nxt;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = status_q;
	assign res.deliver_payload = deliver_q;
	assign res.packet_count    = count_out_q;
	assign res.flow_closed     = closed_q;

	a_deliver_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && deliver_q |-> status_q == ST_OK)
		else $error("payload delivered on a rejected segment");
	a_closed_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && closed_q |-> count_out_q != '0)
		else $error("flow closed with zero packet count");
	a_reject_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && st != ST_OK |=> count_reg_q == $past(count_reg_q))
		else $error("rejected segment changed the packet count");
	a_closed_needs_session: assert property (@(posedge clk) disable iff (!arst_n)
		|side_closed_q |-> session_open_q)
		else $error("side closed without an open session");

endmodule
